/* rtl/tat_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tat_pkg
// Shared types and constants of the track association table.
// ----------------------------------------------------------------------------
package tat_pkg;

   localparam logic [1:0] OP_DETECT  = 2'd0;
   localparam logic [1:0] OP_ADVANCE = 2'd1;
   localparam logic [1:0] OP_PRUNE   = 2'd2;
   localparam logic [1:0] OP_NOP     = 2'd3;

   localparam logic [2:0] ST_MATCHED = 3'd0;
   localparam logic [2:0] ST_NEW     = 3'd1;
   localparam logic [2:0] ST_DROPPED = 3'd2;
   localparam logic [2:0] ST_TIME    = 3'd3;
   localparam logic [2:0] ST_PRUNED  = 3'd4;

   localparam logic        CSR_RANGE_RES = 1'b0;
   localparam logic        CSR_STALE     = 1'b1;

   localparam logic [14:0] AZ_FULL    = 15'd23040;
   localparam logic [14:0] AZ_HALF    = 15'd11520;
   localparam logic [14:0] AZ_GATE    = 15'd384;
   localparam logic [9:0]  W_OLD      = 10'd614;
   localparam logic [9:0]  W_NEW      = 10'd410;
   localparam logic [8:0]  CONF_GAIN  = 9'd38;
   localparam logic [8:0]  CONF_MAX   = 9'd256;
   localparam logic [8:0]  CONF_START = 9'd128;
   localparam logic [8:0]  CONF_FLOOR = 9'd13;

   typedef enum logic [3:0] {
      S_IDLE, S_DSCAN, S_DWAIT, S_DDEC, S_BLEND_R, S_BLEND_A, S_WRITE,
      S_PSCAN, S_PWAIT, S_PDONE, S_RESP
   } state_type;

   // controller to datapath commands
   typedef struct packed {
      logic load;      // capture input item
      logic scan_rd;   // read entry at scan index
      logic scan_eval; // evaluate read entry
      logic scan_inc;  // advance scan index
      logic scan_clr;  // reset scan index and search
      logic rd_best;   // read best entry
      logic blend_r;   // range blend stage
      logic blend_a;   // azimuth blend stage
      logic wr_match;  // write back matched entry
      logic wr_new;    // append entry
      logic prune_eval;// keep or drop read entry
      logic prune_end; // commit new count
      logic time_adv;  // add time step
      logic [2:0] status;
      logic resp_load; // capture result
   } cmd_type;

   typedef struct packed {
      logic scan_done;
      logic found;
      logic full;
   } sts_type;

endpackage
`default_nettype wire

/* rtl/tat_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tat_ctrl
// Sequencer: steps the datapath through scan, blend, write, prune and time advance.
// ----------------------------------------------------------------------------
module tat_ctrl (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output logic                 req_ready,
   input  wire logic [1:0]      req_operation,
   output logic                 rsp_valid,
   input  wire logic            rsp_ready,
   output tat_pkg::cmd_type     cmd,
   input  wire tat_pkg::sts_type sts
);
   import tat_pkg::*;

   state_type state_ff, state_in;
   logic [1:0] op_ff, op_in;
   logic rsp_valid_ff, rsp_valid_in;

   // state, op and response flag registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         op_ff        <= OP_DETECT;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         op_ff        <= op_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   // next state and commands
   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      rsp_valid_in = rsp_valid_ff;
      cmd          = '0;
      req_ready    = 1'b0;
      if (rsp_valid_ff && rsp_ready) rsp_valid_in = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = !rsp_valid_ff || rsp_ready;
            if (req_valid && req_ready) begin
               cmd.load     = 1'b1;
               cmd.scan_clr = 1'b1;
               op_in        = req_operation;
               if (req_operation == OP_DETECT) state_in = S_DSCAN;
               else if (req_operation == OP_PRUNE) state_in = S_PSCAN;
               else begin
                  state_in = S_RESP;
               end
            end
         end
         S_DSCAN: begin
            if (sts.scan_done) state_in = S_DDEC;
            else begin
               cmd.scan_rd = 1'b1;
               state_in    = S_DWAIT;
            end
         end
         S_DWAIT: begin
            cmd.scan_eval = 1'b1;
            cmd.scan_inc  = 1'b1;
            state_in      = S_DSCAN;
         end
         S_DDEC: begin
            if (sts.found) begin
               cmd.rd_best = 1'b1;
               state_in    = S_BLEND_R;
            end else if (sts.full) begin
               cmd.status    = ST_DROPPED;
               cmd.resp_load = 1'b1;
               rsp_valid_in  = 1'b1;
               state_in      = S_IDLE;
            end else begin
               cmd.wr_new    = 1'b1;
               cmd.status    = ST_NEW;
               cmd.resp_load = 1'b1;
               rsp_valid_in  = 1'b1;
               state_in      = S_IDLE;
            end
         end
         S_BLEND_R: begin
            cmd.blend_r = 1'b1;
            state_in    = S_BLEND_A;
         end
         S_BLEND_A: begin
            cmd.blend_a = 1'b1;
            state_in    = S_WRITE;
         end
         S_WRITE: begin
            cmd.wr_match  = 1'b1;
            cmd.status    = ST_MATCHED;
            cmd.resp_load = 1'b1;
            rsp_valid_in  = 1'b1;
            state_in      = S_IDLE;
         end
         S_PSCAN: begin
            if (sts.scan_done) state_in = S_PDONE;
            else begin
               cmd.scan_rd = 1'b1;
               state_in    = S_PWAIT;
            end
         end
         S_PWAIT: begin
            cmd.prune_eval = 1'b1;
            cmd.scan_inc   = 1'b1;
            state_in       = S_PSCAN;
         end
         S_PDONE: begin
            cmd.prune_end = 1'b1;
            cmd.status    = ST_PRUNED;
            cmd.resp_load = 1'b1;
            rsp_valid_in  = 1'b1;
            state_in      = S_IDLE;
         end
         S_RESP: begin
            cmd.time_adv  = (op_ff == OP_ADVANCE);
            cmd.status    = ST_TIME;
            cmd.resp_load = 1'b1;
            rsp_valid_in  = 1'b1;
            state_in      = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end
endmodule
`default_nettype wire

/* rtl/tat_dp.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tat_dp
// Datapath: track memories, gate and score compare, blend, compaction.
// ----------------------------------------------------------------------------
module tat_dp #(
   parameter int MAX_TRACKS = 32
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire tat_pkg::cmd_type cmd,
   output tat_pkg::sts_type      sts,
   input  wire logic            csr_write,
   input  wire logic            csr_index,
   input  wire logic [15:0]     csr_wdata,
   input  wire logic [19:0]     req_det_range,
   input  wire logic [14:0]     req_det_azimuth,
   input  wire logic [15:0]     req_time_step_ms,
   output logic [2:0]           rsp_status,
   output logic [4:0]           rsp_track_index,
   output logic [5:0]           rsp_track_id,
   output logic [19:0]          rsp_track_range,
   output logic [14:0]          rsp_track_azimuth,
   output logic [8:0]           rsp_track_confidence,
   output logic [5:0]           rsp_track_count
);
   import tat_pkg::*;

   localparam int IW = (MAX_TRACKS > 1) ? $clog2(MAX_TRACKS) : 1;
   localparam int CW = $clog2(MAX_TRACKS + 1);

   // track memories
   logic [19:0] mem_range [MAX_TRACKS];
   logic [14:0] mem_az    [MAX_TRACKS];
   logic [8:0]  mem_conf  [MAX_TRACKS];
   logic [31:0] mem_seen  [MAX_TRACKS];
   logic [5:0]  mem_id    [MAX_TRACKS];

   logic [15:0] res_ff, stale_ff;
   logic [CW-1:0] count_ff, scan_ff, keep_ff, best_ff;
   logic [31:0] now_ff;
   logic [19:0] dr_ff;
   logic [14:0] da_ff;
   logic [15:0] step_ff;
   logic found_ff;
   logic [26:0] lead_score_ff;
   logic [19:0] rd_range_ff;
   logic [14:0] rd_az_ff;
   logic [8:0]  rd_conf_ff;
   logic [31:0] rd_seen_ff;
   logic [5:0]  rd_id_ff;
   logic [19:0] new_range_ff;
   logic [14:0] new_az_ff;
   logic [8:0]  new_conf_ff;

   logic [CW-1:0] rd_addr;
   logic [IW-1:0] rd_idx, wr_idx;
   logic          wr_en;
   logic [19:0]   wr_range;
   logic [14:0]   wr_az;
   logic [8:0]    wr_conf;
   logic [31:0]   wr_seen;
   logic [5:0]    wr_id;

   // config registers
   always_ff @(posedge clock) begin
      if (reset) begin
         res_ff   <= 16'd200;
         stale_ff <= 16'd6000;
      end else if (csr_write) begin
         if (csr_index == CSR_RANGE_RES) res_ff <= csr_wdata;
         else stale_ff <= csr_wdata;
      end
   end

   // item capture, azimuth folded into range
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         dr_ff   <= req_det_range;
         da_ff   <= (req_det_azimuth >= AZ_FULL) ? req_det_azimuth - AZ_FULL
                                                : req_det_azimuth;
         step_ff <= req_time_step_ms;
      end
   end

   assign rd_addr = cmd.rd_best ? best_ff : scan_ff;
   assign rd_idx  = rd_addr[IW-1:0];

   // memory read port, registered
   always_ff @(posedge clock) begin
      if (cmd.scan_rd || cmd.rd_best) begin
         rd_range_ff <= mem_range[rd_idx];
         rd_az_ff    <= mem_az[rd_idx];
         rd_conf_ff  <= mem_conf[rd_idx];
         rd_seen_ff  <= mem_seen[rd_idx];
         rd_id_ff    <= mem_id[rd_idx];
      end
   end

   // gate and score of the read entry
   logic [19:0] dr_abs;
   logic [14:0] da_raw, da_abs;
   logic [26:0] score;
   logic        in_gate;
   always_comb begin
      dr_abs  = (rd_range_ff > dr_ff) ? rd_range_ff - dr_ff : dr_ff - rd_range_ff;
      da_raw  = (rd_az_ff > da_ff) ? rd_az_ff - da_ff : da_ff - rd_az_ff;
      da_abs  = (da_raw > AZ_HALF) ? AZ_FULL - da_raw : da_raw;
      score   = {3'd0, dr_abs, 4'd0} + 27'(da_abs) * 27'd100;
      in_gate = ({dr_abs, 1'b0} < 21'(18'(res_ff) * 18'd3)) && (da_abs < AZ_GATE);
   end

   // prune keep test
   logic [31:0] age;
   logic        keep_it;
   assign age     = now_ff - rd_seen_ff;
   assign keep_it = !(age > {16'd0, stale_ff}) && !(rd_conf_ff < CONF_FLOOR);

   // scan, best search, compaction and clock
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         now_ff   <= '0;
         scan_ff  <= '0;
         keep_ff  <= '0;
         best_ff  <= '0;
         found_ff <= 1'b0;
      end else begin
         if (cmd.scan_clr) begin
            scan_ff  <= '0;
            keep_ff  <= '0;
            found_ff <= 1'b0;
         end
         if (cmd.scan_inc) scan_ff <= scan_ff + 1'b1;
         if (cmd.scan_eval && in_gate && (!found_ff || score < lead_score_ff)) begin
            found_ff <= 1'b1;
            best_ff  <= scan_ff;
         end
         if (cmd.prune_eval && keep_it) keep_ff <= keep_ff + 1'b1;
         if (cmd.prune_end) count_ff <= keep_ff;
         if (cmd.wr_new) count_ff <= count_ff + 1'b1;
         if (cmd.time_adv) now_ff <= now_ff + {16'd0, step_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.scan_eval && in_gate && (!found_ff || score < lead_score_ff))
         lead_score_ff <= score;
   end

   // blend stages: range blend, then azimuth blend and confidence
   logic [30:0] blend_r, blend_a;
   logic [14:0] az_sm;
   logic [8:0]  conf_up;
   assign blend_r = 31'(rd_range_ff) * 31'(W_OLD) + 31'(dr_ff) * 31'(W_NEW) + 31'd512;
   assign blend_a = 31'(rd_az_ff) * 31'(W_OLD) + 31'(da_ff) * 31'(W_NEW) + 31'd512;
   assign az_sm   = blend_a[24:10];
   assign conf_up = (rd_conf_ff + CONF_GAIN > CONF_MAX) ? CONF_MAX : rd_conf_ff + CONF_GAIN;

   always_ff @(posedge clock) begin
      if (cmd.blend_r) new_range_ff <= blend_r[29:10];
      if (cmd.blend_a) begin
         new_az_ff   <= (az_sm >= AZ_FULL) ? az_sm - AZ_FULL : az_sm;
         new_conf_ff <= conf_up;
      end
   end

   // write port select
   always_comb begin
      wr_en    = 1'b0;
      wr_idx   = count_ff[IW-1:0];
      wr_range = dr_ff;
      wr_az    = da_ff;
      wr_conf  = CONF_START;
      wr_seen  = now_ff;
      wr_id    = 6'(count_ff + 1'b1);
      if (cmd.wr_new) wr_en = 1'b1;
      else if (cmd.wr_match) begin
         wr_en    = 1'b1;
         wr_idx   = best_ff[IW-1:0];
         wr_range = new_range_ff;
         wr_az    = new_az_ff;
         wr_conf  = new_conf_ff;
         wr_id    = rd_id_ff;
      end else if (cmd.prune_eval && keep_it) begin
         wr_en    = 1'b1;
         wr_idx   = keep_ff[IW-1:0];
         wr_range = rd_range_ff;
         wr_az    = rd_az_ff;
         wr_conf  = rd_conf_ff;
         wr_seen  = rd_seen_ff;
         wr_id    = rd_id_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_range[wr_idx] <= wr_range;
         mem_az[wr_idx]    <= wr_az;
         mem_conf[wr_idx]  <= wr_conf;
         mem_seen[wr_idx]  <= wr_seen;
         mem_id[wr_idx]    <= wr_id;
      end
   end

   assign sts.scan_done = (scan_ff >= count_ff);
   assign sts.found     = found_ff;
   assign sts.full      = (count_ff >= CW'(MAX_TRACKS));

   // result register
   always_ff @(posedge clock) begin
      if (cmd.resp_load) begin
         rsp_status           <= cmd.status;
         rsp_track_index      <= 5'd0;
         rsp_track_id         <= 6'd0;
         rsp_track_range      <= 20'd0;
         rsp_track_azimuth    <= 15'd0;
         rsp_track_confidence <= 9'd0;
         rsp_track_count      <= 6'(count_ff);
         if (cmd.wr_new) begin
            rsp_track_index      <= 5'(count_ff);
            rsp_track_id         <= 6'(count_ff + 1'b1);
            rsp_track_range      <= dr_ff;
            rsp_track_azimuth    <= da_ff;
            rsp_track_confidence <= CONF_START;
            rsp_track_count      <= 6'(count_ff + 1'b1);
         end else if (cmd.wr_match) begin
            rsp_track_index      <= 5'(best_ff);
            rsp_track_id         <= rd_id_ff;
            rsp_track_range      <= new_range_ff;
            rsp_track_azimuth    <= new_az_ff;
            rsp_track_confidence <= new_conf_ff;
         end else if (cmd.prune_end) begin
            rsp_track_count      <= 6'(keep_ff);
         end
      end
   end
endmodule
`default_nettype wire

/* rtl/track_association_table.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// track_association_table
// Ordered radar track table with gated nearest-neighbor association.
// ----------------------------------------------------------------------------
// One item at a time. A detection reads every stored track once through a
// single registered memory port, with a read state and an evaluate state per
// track. A matched detection then passes end of scan, decision, two blend
// stages and write before its result is loaded; a new or dropped one ends at
// the decision, a prune at its final count, a time advance in one response state.
// The controller takes the next item only once it is back in idle, and only
// when the output register is empty or empties in the same cycle.
module track_association_table #(
   parameter int MAX_TRACKS = 32
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [1:0]  req_operation,
   input  wire logic [19:0] req_det_range,
   input  wire logic [14:0] req_det_azimuth,
   input  wire logic [15:0] req_time_step_ms,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [2:0]       rsp_status,
   output logic [4:0]       rsp_track_index,
   output logic [5:0]       rsp_track_id,
   output logic [19:0]      rsp_track_range,
   output logic [14:0]      rsp_track_azimuth,
   output logic [8:0]       rsp_track_confidence,
   output logic [5:0]       rsp_track_count,
   input  wire logic        csr_write,
   input  wire logic        csr_index,
   input  wire logic [15:0] csr_wdata
);
   import tat_pkg::*;

   cmd_type cmd;
   sts_type sts;

   tat_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_ready, .req_operation,
      .rsp_valid, .rsp_ready, .cmd, .sts
   );

   tat_dp #(.MAX_TRACKS(MAX_TRACKS)) u_dp (
      .clock, .reset, .cmd, .sts, .csr_write, .csr_index, .csr_wdata,
      .req_det_range, .req_det_azimuth, .req_time_step_ms,
      .rsp_status, .rsp_track_index, .rsp_track_id, .rsp_track_range,
      .rsp_track_azimuth, .rsp_track_confidence, .rsp_track_count
   );

   // never a new and a matched write at once
   a_one_write: assert property (@(posedge clock) disable iff (reset)
      !(cmd.wr_new && cmd.wr_match)) else $error("double write");
   // a result is loaded only when the output register is free or draining
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      cmd.resp_load |-> (!rsp_valid || rsp_ready)) else $error("result overrun");
   // no transfer in while a scan is at work
   a_busy: assert property (@(posedge clock) disable iff (reset)
      (cmd.scan_rd || cmd.scan_eval || cmd.prune_eval) |-> !req_ready)
      else $error("accept while busy");
endmodule
`default_nettype wire

/* tb/tb_track_association_table.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_track_association_table
// Self-checking bench for the track association table: a software copy of
// the table predicts every result, and each transfer is compared by field.
// ----------------------------------------------------------------------------
module tb_track_association_table;
   import tat_pkg::*;

   localparam int NTRK = 32;

   typedef struct packed {
      logic [2:0]  status;
      logic [4:0]  index;
      logic [5:0]  id;
      logic [19:0] range;
      logic [14:0] azimuth;
      logic [8:0]  conf;
      logic [5:0]  count;
   } track_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_operation = '0;
   logic [19:0] req_det_range = '0;
   logic [14:0] req_det_azimuth = '0;
   logic [15:0] req_time_step_ms = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [2:0]  rsp_status;
   logic [4:0]  rsp_track_index;
   logic [5:0]  rsp_track_id;
   logic [19:0] rsp_track_range;
   logic [14:0] rsp_track_azimuth;
   logic [8:0]  rsp_track_confidence;
   logic [5:0]  rsp_track_count;
   logic        csr_write = 1'b0;
   logic        csr_index = 1'b0;
   logic [15:0] csr_wdata = '0;

   track_association_table dut (.*);

   // predictor state
   logic [19:0] tk_range [NTRK];
   logic [14:0] tk_az [NTRK];
   logic [8:0]  tk_conf [NTRK];
   logic [31:0] tk_seen [NTRK];
   logic [5:0]  tk_id [NTRK];
   int unsigned tk_count;
   logic [31:0] clock_ms;
   logic [15:0] gate_res;
   logic [15:0] stale_ms;

   track_result_type expected_results[$];
   int errors = 0;
   int checked = 0;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;

   initial forever #1 clock = ~clock;

   initial begin
      #10000000;
      $display("track_association_table test failed");
      $finish;
   end

   function automatic logic [31:0] smooth(logic [31:0] old_v, logic [31:0] new_v);
      logic [63:0] s;
      s = 64'd614 * old_v + 64'd410 * new_v + 64'd512;
      return s[41:10];
   endfunction

   // compute expected result and update the table copy
   function automatic track_result_type associate(logic [1:0] op, logic [19:0] rng,
                                                  logic [14:0] az, logic [15:0] step);
      track_result_type r;
      logic [31:0] a_in, dr, da, age;
      logic [63:0] score, low_score;
      logic found;
      int best, keep;
      r = '0;
      if (op == OP_DETECT) begin
         a_in = {17'd0, az};
         if (a_in >= 23040) a_in -= 23040;
         found = 1'b0;
         best = 0;
         low_score = 0;
         for (int i = 0; i < tk_count; i++) begin
            dr = tk_range[i] > rng ? tk_range[i] - rng : rng - tk_range[i];
            da = tk_az[i] > a_in ? tk_az[i] - a_in : a_in - tk_az[i];
            if (da > 11520) da = 23040 - da;
            score = 64'd16 * dr + 64'd100 * da;
            if (64'd2 * dr < 64'd3 * gate_res && da < 384
                && (!found || score < low_score)) begin
               found = 1'b1;
               best = i;
               low_score = score;
            end
         end
         if (found) begin
            tk_range[best] = 20'(smooth(tk_range[best], rng));
            a_in = smooth(tk_az[best], a_in);
            if (a_in >= 23040) a_in -= 23040;
            tk_az[best] = 15'(a_in);
            tk_conf[best] = (tk_conf[best] + 38 > 256) ? 9'd256 : tk_conf[best] + 9'd38;
            tk_seen[best] = clock_ms;
            r = '{ST_MATCHED, 5'(best), tk_id[best], tk_range[best], tk_az[best],
                  tk_conf[best], 6'(tk_count)};
         end else if (tk_count >= NTRK) begin
            r.status = ST_DROPPED;
            r.count = 6'(tk_count);
         end else begin
            tk_id[tk_count] = 6'(tk_count + 1);
            tk_range[tk_count] = rng;
            tk_az[tk_count] = 15'(a_in);
            tk_conf[tk_count] = 9'd128;
            tk_seen[tk_count] = clock_ms;
            r = '{ST_NEW, 5'(tk_count), 6'(tk_count + 1), rng, 15'(a_in), 9'd128,
                  6'(tk_count + 1)};
            tk_count++;
         end
      end else if (op == OP_PRUNE) begin
         keep = 0;
         for (int i = 0; i < tk_count; i++) begin
            age = clock_ms - tk_seen[i];
            if (age > stale_ms || tk_conf[i] < 13) continue;
            tk_range[keep] = tk_range[i];
            tk_az[keep] = tk_az[i];
            tk_conf[keep] = tk_conf[i];
            tk_seen[keep] = tk_seen[i];
            tk_id[keep] = tk_id[i];
            keep++;
         end
         tk_count = keep;
         r.status = ST_PRUNED;
         r.count = 6'(tk_count);
      end else begin
         if (op == OP_ADVANCE) clock_ms += step;
         r.status = ST_TIME;
         r.count = 6'(tk_count);
      end
      return r;
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      $display("mismatch %0d: %s got %0d want %0d", checked, what, got, want);
      errors++;
   endtask

   // one item transfer on the request channel; valid stays up for a follow-on item
   task automatic send_item(logic [1:0] op, logic [19:0] rng, logic [14:0] az,
                            logic [15:0] step);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_operation <= op;
      req_det_range <= rng;
      req_det_azimuth <= az;
      req_time_step_ms <= step;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      expected_results = {expected_results, associate(op, rng, az, step)};
      @(negedge clock);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (expected_results.size() != 0) @(negedge clock);
      repeat (100) @(negedge clock);
   endtask

   task automatic write_csr(logic idx, logic [15:0] val);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_write <= 1'b0;
      if (idx == CSR_RANGE_RES) gate_res = val;
      else stale_ms = val;
      @(negedge clock);
   endtask

   // receiver stall and result check
   always @(negedge clock) rsp_ready <= ($urandom_range(99) >= recv_stall_pct);

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         track_result_type e;
         if (expected_results.size() == 0) begin
            $display("unexpected result transfer");
            errors++;
         end else begin
            e = expected_results.pop_front();
            if (rsp_status !== e.status) report_mismatch("status", rsp_status, e.status);
            if (rsp_track_index !== e.index)
               report_mismatch("index", rsp_track_index, e.index);
            if (rsp_track_id !== e.id) report_mismatch("id", rsp_track_id, e.id);
            if (rsp_track_range !== e.range)
               report_mismatch("range", rsp_track_range, e.range);
            if (rsp_track_azimuth !== e.azimuth)
               report_mismatch("azimuth", rsp_track_azimuth, e.azimuth);
            if (rsp_track_confidence !== e.conf)
               report_mismatch("confidence", rsp_track_confidence, e.conf);
            if (rsp_track_count !== e.count)
               report_mismatch("count", rsp_track_count, e.count);
            checked++;
         end
      end
   end

   // extremes, every operation, azimuth wrap, full table, unused op
   task automatic test_directed();
      send_item(OP_DETECT, 20'd0, 15'd0, 16'd0);
      send_item(OP_DETECT, 20'd100, 15'd10, 16'd0);
      send_item(OP_DETECT, 20'hFFFFF, 15'h7FFF, 16'hFFFF);
      send_item(OP_DETECT, 20'd5000, 15'd23039, 16'd0);
      send_item(OP_DETECT, 20'd5010, 15'd5, 16'd0);
      send_item(OP_DETECT, 20'd9000, 15'd23040, 16'd0);
      send_item(OP_ADVANCE, 20'hFFFFF, 15'h7FFF, 16'hFFFF);
      send_item(OP_NOP, 20'hFFFFF, 15'h7FFF, 16'hFFFF);
      send_item(OP_PRUNE, 20'd0, 15'd0, 16'd0);
      for (int i = 0; i < 34; i++) send_item(OP_DETECT, 20'(i * 30000), 15'd1000, 16'd0);
      drain();
      write_csr(CSR_RANGE_RES, 16'd0);
      send_item(OP_DETECT, 20'd30000, 15'd1000, 16'd0);
      send_item(OP_PRUNE, 20'd0, 15'd0, 16'd0);
      drain();
   endtask

   // clustered detections so matches dominate, with time and prune mixed in
   task automatic test_random(int n, int idle, int stall);
      int k;
      send_idle_pct = idle;
      recv_stall_pct = stall;
      for (int i = 0; i < n; i++) begin
         k = $urandom_range(99);
         if (k < 5) send_item(OP_PRUNE, 20'($urandom), 15'($urandom), 16'($urandom));
         else if (k < 12)
            send_item(OP_ADVANCE, 20'($urandom), 15'($urandom), 16'($urandom_range(3000)));
         else if (k < 14)
            send_item(OP_ADVANCE, 20'($urandom), 15'($urandom), 16'($urandom));
         else if (k < 15) send_item(OP_NOP, 20'($urandom), 15'($urandom), 16'($urandom));
         else if (k < 25)
            send_item(OP_DETECT, 20'($urandom), 15'($urandom), 16'($urandom));
         else send_item(OP_DETECT, 20'($urandom_range(20) * 40000 + $urandom_range(300)),
                        15'(($urandom_range(15) * 1440 + 23040 - 200 + $urandom_range(400))
                            % 23040), 16'($urandom));
      end
      drain();
   endtask

   initial begin
      tk_count = 0;
      clock_ms = 0;
      gate_res = 16'd200;
      stale_ms = 16'd6000;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      write_csr(CSR_RANGE_RES, 16'd200);
      write_csr(CSR_STALE, 16'd6000);
      test_random(500, 0, 0);
      write_csr(CSR_RANGE_RES, 16'hFFFF);
      write_csr(CSR_STALE, 16'd0);
      test_random(500, 47, 0);
      write_csr(CSR_RANGE_RES, 16'd1);
      write_csr(CSR_STALE, 16'hFFFF);
      test_random(500, 0, 47);
      write_csr(CSR_RANGE_RES, 16'd400);
      write_csr(CSR_STALE, 16'd4000);
      test_random(500, 22, 22);
      $display("covered detect, advance, prune and unused op with %0d results checked",
               checked);
      $display("gate and timeout settings spanned both extremes under idle and stall");
      if (errors == 0 && expected_results.size() == 0)
         $display("track_association_table test passed");
      else
         $display("track_association_table test failed");
      $finish;
   end

endmodule

/* files.f */
rtl/tat_pkg.sv
rtl/tat_ctrl.sv
rtl/tat_dp.sv
rtl/track_association_table.sv
tb/tb_track_association_table.sv
